>>> sv/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property sampled on clk_i, disabled while rst_ni is low.
`define ASSERT_CLKRST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Property sampled on clk_i, also checked during reset.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

>>> sv/hkrd_pkg.sv
`timescale 1ns / 1ps

package hkrd_pkg;

  // Report geometry
  localparam int KeySlots    = 6;
  localparam int EventSlots  = 2 * KeySlots;
  localparam int QueueDepth  = 2;
  localparam int QPtrW       = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int QCountW     = $clog2(QueueDepth + 1);

  // Modifier byte masks (left | right)
  localparam logic [7:0] ModCtrlMask  = 8'h11;
  localparam logic [7:0] ModShiftMask = 8'h22;
  localparam logic [7:0] ModAltMask   = 8'h44;

  typedef logic [7:0] usage_t;
  typedef usage_t [KeySlots-1:0] keys_t;

  // One pending report: candidate usages (new slots low, old slots high),
  // which of them produce an event, and the modifier flags.
  typedef struct packed {
    logic [EventSlots-1:0]         mask;
    usage_t [EventSlots-1:0]       code;
    logic                          shift;
    logic                          ctrl;
    logic                          alt;
  } job_t;

  // Usages that have a translation
  function automatic logic usage_known(input usage_t u);
    logic known;
    known = ((u >= 8'h04) && (u <= 8'h31)) ||
            ((u >= 8'h33) && (u <= 8'h45)) ||
            ((u >= 8'h49) && (u <= 8'h63)) ||
            (u == 8'h65) ||
            ((u >= 8'h87) && (u <= 8'h8B));
    return known;
  endfunction

  // True if u sits in any slot of keys
  function automatic logic slot_member(input keys_t keys, input usage_t u);
    logic hit;
    hit = 1'b0;
    for (int j = 0; j < KeySlots; j++) begin
      hit = hit | (keys[j] == u);
    end
    return hit;
  endfunction

endpackage

>>> sv/hkrd_front.sv
`timescale 1ns / 1ps

module hkrd_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic [7:0]     modifier_bits_i,
  input  hkrd_pkg::keys_t keys_i,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  logic           q_full_i,
  output logic           q_push_o,
  output hkrd_pkg::job_t q_job_o
);

  hkrd_pkg::keys_t prev_q, prev_d;
  logic            accept;
  logic [hkrd_pkg::KeySlots-1:0] press_mask, release_mask;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && !q_full_i;

  // Membership compare of new against old slots and back
  always_comb begin
    for (int i = 0; i < hkrd_pkg::KeySlots; i++) begin
      press_mask[i]   = (keys_i[i] != 8'h00) &&
                        !hkrd_pkg::slot_member(prev_q, keys_i[i]) &&
                        hkrd_pkg::usage_known(keys_i[i]);
      release_mask[i] = (prev_q[i] != 8'h00) &&
                        !hkrd_pkg::slot_member(keys_i, prev_q[i]) &&
                        hkrd_pkg::usage_known(prev_q[i]);
    end
  end

  // Build the job beat for the queue
  always_comb begin
    q_job_o.mask  = {release_mask, press_mask};
    q_job_o.code  = {prev_q, keys_i};
    q_job_o.shift = |(modifier_bits_i & hkrd_pkg::ModShiftMask);
    q_job_o.ctrl  = |(modifier_bits_i & hkrd_pkg::ModCtrlMask);
    q_job_o.alt   = |(modifier_bits_i & hkrd_pkg::ModAltMask);
  end

  // Reports with no events are dropped here
  assign q_push_o = accept && (|press_mask || |release_mask);

  assign prev_d = accept ? keys_i : prev_q;

  // Previous report
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= '0;
    end else begin
      prev_q <= prev_d;
    end
  end

endmodule

>>> sv/hkrd_fifo.sv
`timescale 1ns / 1ps

module hkrd_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  hkrd_pkg::job_t push_data_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output hkrd_pkg::job_t pop_data_o
);

  hkrd_pkg::job_t mem_q [hkrd_pkg::QueueDepth];
  logic [hkrd_pkg::QPtrW-1:0]   wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [hkrd_pkg::QCountW-1:0] count_q, count_d;
  logic                         do_push, do_pop;

  assign full_o     = (count_q == hkrd_pkg::QCountW'(hkrd_pkg::QueueDepth));
  assign valid_o    = (count_q != '0);
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && valid_o;
  assign pop_data_o = mem_q[rd_ptr_q];

  // Pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == hkrd_pkg::QPtrW'(hkrd_pkg::QueueDepth - 1)) ? '0
                 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == hkrd_pkg::QPtrW'(hkrd_pkg::QueueDepth - 1)) ? '0
                 : rd_ptr_q + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

>>> sv/hkrd_back.sv
`timescale 1ns / 1ps

module hkrd_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           q_valid_i,
  input  hkrd_pkg::job_t q_job_i,
  output logic           q_pop_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic [7:0]     usage_code_o,
  output logic           is_press_o,
  output logic           shift_held_o,
  output logic           ctrl_held_o,
  output logic           alt_held_o,
  output logic           last_event_o
);

  hkrd_pkg::job_t job_q, job_d;
  logic           active_q, active_d;
  logic           out_valid_q, out_valid_d;
  logic [7:0]     usage_q, usage_d;
  logic           press_q, press_d, last_q, last_d;
  logic           shift_q, ctrl_q, alt_q;
  logic [hkrd_pkg::EventSlots-1:0] pick;
  logic           emit, emit_last;

  // Lowest pending event goes next
  assign pick      = job_q.mask & (~job_q.mask + 1'b1);
  assign emit      = active_q && (!out_valid_q || out_ready_i);
  assign emit_last = ((job_q.mask & ~pick) == '0);
  assign q_pop_o   = q_valid_i && (!active_q || (emit && emit_last));

  always_comb begin
    usage_d = '0;
    for (int i = 0; i < hkrd_pkg::EventSlots; i++) begin
      usage_d = usage_d | (job_q.code[i] & {8{pick[i]}});
    end
    press_d = |pick[hkrd_pkg::KeySlots-1:0];
    last_d  = emit_last;
  end

  // Job register and walk through its event mask
  always_comb begin
    job_d    = job_q;
    active_d = active_q;
    if (emit) begin
      job_d.mask = job_q.mask & ~pick;
      if (emit_last) begin
        active_d = 1'b0;
      end
    end
    if (q_pop_o) begin
      job_d    = q_job_i;
      active_d = 1'b1;
    end
  end

  // Output register valid
  always_comb begin
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      active_q    <= active_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q <= job_d;
    if (emit) begin
      usage_q <= usage_d;
      press_q <= press_d;
      last_q  <= last_d;
      shift_q <= job_q.shift;
      ctrl_q  <= job_q.ctrl;
      alt_q   <= job_q.alt;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign usage_code_o = usage_q;
  assign is_press_o   = press_q;
  assign last_event_o = last_q;
  assign shift_held_o = shift_q;
  assign ctrl_held_o  = ctrl_q;
  assign alt_held_o   = alt_q;

endmodule

>>> sv/hid_keyboard_report_diff.sv
`timescale 1ns / 1ps

// Boot keyboard report to key events. Each accepted report is compared with
// the one before; presses for new slots come first in slot order, then
// releases for old slots, one event beat per cycle unless the output stalls,
// with last_event on the final beat of a report. Reports that change no key
// (and keys without a translation) give no beats. The input side takes a
// report every cycle as long as the two-entry job queue has room; a report
// with 1 to 12 events holds the event serializer until its last event, so
// the sustained rate is set by the event count per report and by output
// back-pressure. Beats pass the job queue and the job and output registers.
module hid_keyboard_report_diff (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] modifier_bits_i,
  input  logic [7:0] key_slot_0_i,
  input  logic [7:0] key_slot_1_i,
  input  logic [7:0] key_slot_2_i,
  input  logic [7:0] key_slot_3_i,
  input  logic [7:0] key_slot_4_i,
  input  logic [7:0] key_slot_5_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] usage_code_o,
  output logic       is_press_o,
  output logic       shift_held_o,
  output logic       ctrl_held_o,
  output logic       alt_held_o,
  output logic       last_event_o
);

  hkrd_pkg::keys_t keys;
  hkrd_pkg::job_t  push_job, pop_job;
  logic            q_full, q_push, q_valid, q_pop;

  assign keys = {key_slot_5_i, key_slot_4_i, key_slot_3_i,
                 key_slot_2_i, key_slot_1_i, key_slot_0_i};

  // Compare and classify
  hkrd_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .modifier_bits_i (modifier_bits_i),
    .keys_i          (keys),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .q_full_i        (q_full),
    .q_push_o        (q_push),
    .q_job_o         (push_job)
  );

  // Job queue
  hkrd_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (push_job),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .pop_data_o  (pop_job)
  );

  // Event serializer
  hkrd_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_valid_i    (q_valid),
    .q_job_i      (pop_job),
    .q_pop_o      (q_pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .usage_code_o (usage_code_o),
    .is_press_o   (is_press_o),
    .shift_held_o (shift_held_o),
    .ctrl_held_o  (ctrl_held_o),
    .alt_held_o   (alt_held_o),
    .last_event_o (last_event_o)
  );

endmodule

>>> sv/hkrd_checker.sv
`timescale 1ns / 1ps

`include "assert_macros.svh"

module hkrd_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [7:0] usage_code_o,
  input logic       is_press_o,
  input logic       last_event_o
);

  // A stalled beat holds its payload
  `ASSERT_CLKRST(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o && $stable(usage_code_o) && $stable(is_press_o) && $stable(last_event_o), "stalled event beat changed")

  // Empty slots and untranslated usages never make it out
  `ASSERT_CLKRST(a_usage_range, out_valid_o |-> (usage_code_o >= 8'h04) && (usage_code_o <= 8'h8B) && (usage_code_o != 8'h32), "event usage outside table")

  // Nothing left in the output register straight out of reset
  `ASSERT_CLK(a_reset_idle, !rst_ni |=> !out_valid_o, "output valid after reset")

endmodule

bind hid_keyboard_report_diff hkrd_checker u_hkrd_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .usage_code_o (usage_code_o),
  .is_press_o   (is_press_o),
  .last_event_o (last_event_o)
);

>>> dv/testbench.sv
`timescale 1ns / 1ps

module testbench;

  // One key event as seen on the output side
  typedef struct {
    hkrd_pkg::usage_t code;
    logic   press;
    logic   shift;
    logic   ctrl;
    logic   alt;
    logic   is_last;
  } key_event_t;

  // Directed stimulus row; n_typed < 0 means the predictor supplies the events
  typedef struct {
    logic [7:0]      mods;
    hkrd_pkg::keys_t keys;
    int              n_typed;
    key_event_t      ev;
  } report_row_t;

  logic       clk_i      = 1'b0;
  logic       rst_ni     = 1'b0;
  logic       in_valid   = 1'b0;
  logic       in_ready;
  logic [7:0] in_mods    = 8'h00;
  hkrd_pkg::keys_t in_keys = '0;
  logic       out_valid;
  logic       out_ready  = 1'b0;
  hkrd_pkg::usage_t usage_code;
  logic       is_press;
  logic       shift_held;
  logic       ctrl_held;
  logic       alt_held;
  logic       last_event;

  hkrd_pkg::keys_t held_keys = '0;   // predictor's copy of the previous report
  hkrd_pkg::keys_t last_sent = '0;   // last report driven, seeds the random walk
  key_event_t    expected_events[$];
  report_row_t   directed_rows[$];
  int            mismatch_count = 0;
  int            hold_cycles    = 0;
  bit            no_gaps        = 1'b0;

  hid_keyboard_report_diff DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .modifier_bits_i (in_mods),
    .key_slot_0_i    (in_keys[0]),
    .key_slot_1_i    (in_keys[1]),
    .key_slot_2_i    (in_keys[2]),
    .key_slot_3_i    (in_keys[3]),
    .key_slot_4_i    (in_keys[4]),
    .key_slot_5_i    (in_keys[5]),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .usage_code_o    (usage_code),
    .is_press_o      (is_press),
    .shift_held_o    (shift_held),
    .ctrl_held_o     (ctrl_held),
    .alt_held_o      (alt_held),
    .last_event_o    (last_event)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Hard stop well beyond the slowest legal run
  initial begin
    #2000000;
    $display("testbench: FAIL");
    $finish;
  end

  // Usages that carry a translation
  function automatic bit is_translated(input hkrd_pkg::usage_t u);
    return ((u >= 8'h04) && (u <= 8'h31)) || ((u >= 8'h33) && (u <= 8'h45)) ||
           ((u >= 8'h49) && (u <= 8'h63)) || (u == 8'h65) ||
           ((u >= 8'h87) && (u <= 8'h8B));
  endfunction

  function automatic bit has_usage(input hkrd_pkg::keys_t keys, input hkrd_pkg::usage_t u);
    bit hit;
    hit = 1'b0;
    for (int j = 0; j < hkrd_pkg::KeySlots; j++) begin
      if (keys[j] == u) hit = 1'b1;
    end
    return hit;
  endfunction

  // Events caused by one report: presses of new slots, then releases of old
  // slots, both in slot order; updates the held keys.
  function automatic void predict_key_events(input logic [7:0] mods,
                                             input hkrd_pkg::keys_t keys,
                                             ref key_event_t evs[$]);
    key_event_t ev;
    evs = {};
    ev.shift   = |(mods & hkrd_pkg::ModShiftMask);
    ev.ctrl    = |(mods & hkrd_pkg::ModCtrlMask);
    ev.alt     = |(mods & hkrd_pkg::ModAltMask);
    ev.is_last = 1'b0;
    for (int i = 0; i < hkrd_pkg::KeySlots; i++) begin
      if (keys[i] != 8'h00 && !has_usage(held_keys, keys[i]) && is_translated(keys[i])) begin
        ev.code  = keys[i];
        ev.press = 1'b1;
        evs.push_back(ev);
      end
    end
    for (int i = 0; i < hkrd_pkg::KeySlots; i++) begin
      if (held_keys[i] != 8'h00 && !has_usage(keys, held_keys[i]) &&
          is_translated(held_keys[i])) begin
        ev.code  = held_keys[i];
        ev.press = 1'b0;
        evs.push_back(ev);
      end
    end
    held_keys = keys;
    if (evs.size() > 0) evs[evs.size()-1].is_last = 1'b1;
  endfunction

  function automatic hkrd_pkg::keys_t make_keys(
      input hkrd_pkg::usage_t s0, input hkrd_pkg::usage_t s1, input hkrd_pkg::usage_t s2,
      input hkrd_pkg::usage_t s3, input hkrd_pkg::usage_t s4, input hkrd_pkg::usage_t s5);
    hkrd_pkg::keys_t k;
    k[0] = s0;
    k[1] = s1;
    k[2] = s2;
    k[3] = s3;
    k[4] = s4;
    k[5] = s5;
    return k;
  endfunction

  function automatic hkrd_pkg::usage_t random_known();
    hkrd_pkg::usage_t u;
    do u = 8'($urandom_range(8'h04, 8'h8B)); while (!is_translated(u));
    return u;
  endfunction

  // Mostly typing-like reports that evolve from the last one, plus noise
  function automatic hkrd_pkg::keys_t random_keys();
    hkrd_pkg::keys_t k;
    int    pick;
    int    r;
    pick = $urandom_range(0, 99);
    for (int i = 0; i < hkrd_pkg::KeySlots; i++) begin
      r = $urandom_range(0, 99);
      if (pick < 10) k[i] = last_sent[i];
      else if (pick < 80) begin
        if (r < 50) k[i] = last_sent[i];
        else if (r < 70) k[i] = 8'h00;
        else if (r < 95) k[i] = random_known();
        else k[i] = 8'($urandom_range(0, 255));
      end else if (pick < 90) k[i] = 8'($urandom_range(0, 255));
      else k[i] = random_known();
    end
    return k;
  endfunction

  task automatic add_row(input logic [7:0] mods, input hkrd_pkg::keys_t k,
                         input int n_typed = -1,
                         input hkrd_pkg::usage_t code = 8'h00, input logic press = 1'b0);
    report_row_t row;
    row.mods       = mods;
    row.keys       = k;
    row.n_typed    = n_typed;
    row.ev.code    = code;
    row.ev.press   = press;
    row.ev.shift   = |(mods & hkrd_pkg::ModShiftMask);
    row.ev.ctrl    = |(mods & hkrd_pkg::ModCtrlMask);
    row.ev.alt     = |(mods & hkrd_pkg::ModAltMask);
    row.ev.is_last = 1'b1;
    directed_rows.push_back(row);
  endtask

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $time, what);
    mismatch_count++;
  endtask

  // Drive one report beat and wait for it to be taken
  task automatic send_report(input logic [7:0] mods, input hkrd_pkg::keys_t keys);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_mods  <= mods;
    in_keys  <= keys;
    do @(posedge clk_i); while (!in_ready);
    last_sent = keys;
  endtask

  // Hold off the input until every outstanding event has drained
  task automatic wait_for_events();
    in_valid <= 1'b0;
    do @(posedge clk_i); while (expected_events.size() != 0);
  endtask

  task automatic queue_events(input logic [7:0] mods, input hkrd_pkg::keys_t keys,
                              input int n_typed, input key_event_t typed_ev);
    key_event_t evs[$];
    predict_key_events(mods, keys, evs);
    if (n_typed >= 0) begin
      evs = {};
      if (n_typed == 1) evs.push_back(typed_ev);
    end
    foreach (evs[i]) expected_events.push_back(evs[i]);
  endtask

  task automatic check_beat();
    key_event_t exp;
    if (expected_events.size() == 0) begin
      report_mismatch($sformatf("event beat with nothing pending, usage %02h", usage_code));
      return;
    end
    exp = expected_events.pop_front();
    if (usage_code !== exp.code)
      report_mismatch($sformatf("usage_code %02h, want %02h", usage_code, exp.code));
    if (is_press !== exp.press)
      report_mismatch($sformatf("is_press %b, want %b (usage %02h)", is_press, exp.press,
                                exp.code));
    if (shift_held !== exp.shift)
      report_mismatch($sformatf("shift_held %b, want %b", shift_held, exp.shift));
    if (ctrl_held !== exp.ctrl)
      report_mismatch($sformatf("ctrl_held %b, want %b", ctrl_held, exp.ctrl));
    if (alt_held !== exp.alt)
      report_mismatch($sformatf("alt_held %b, want %b", alt_held, exp.alt));
    if (last_event !== exp.is_last)
      report_mismatch($sformatf("last_event %b, want %b (usage %02h)", last_event,
                                exp.is_last, exp.code));
  endtask

  // Event side: check each beat, then stall for a random number of cycles
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        check_beat();
        hold_cycles = no_gaps ? 0 : $urandom_range(0, 6);
      end
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Report side
  initial begin
    report_row_t     row;
    logic [7:0]      mods;
    hkrd_pkg::keys_t keys;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // empty report right after reset, then one key with shift
    add_row(8'h00, make_keys(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00), 0);
    add_row(8'h02, make_keys(8'h04, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00), 1, 8'h04, 1'b1);
    // modifier change alone
    add_row(8'h20, make_keys(8'h04, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00), 0);
    add_row(8'h00, make_keys(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00), 1, 8'h04, 1'b0);
    // untranslated usage: stored but silent on press and release
    add_row(8'h00, make_keys(8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00), 0);
    add_row(8'h00, make_keys(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00), 0);
    // table edges, all modifiers
    add_row(8'hFF, make_keys(8'h04, 8'h31, 8'h33, 8'h45, 8'h49, 8'h63));
    // six new, six gone: twelve events
    add_row(8'h01, make_keys(8'h65, 8'h87, 8'h8B, 8'h05, 8'h06, 8'h07));
    // just outside the table ranges
    add_row(8'h44, make_keys(8'h32, 8'h46, 8'h47, 8'h48, 8'h64, 8'h66));
    add_row(8'h02, make_keys(8'h03, 8'h86, 8'h8C, 8'h01, 8'h02, 8'h00));
    // repeated usage, gui bits only
    add_row(8'h88, make_keys(8'h88, 8'h88, 8'h88, 8'h00, 8'h00, 8'h00));
    add_row(8'h88, make_keys(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h88), 0);
    add_row(8'h40, make_keys(8'h8A, 8'h8A, 8'h00, 8'h00, 8'h00, 8'h00));
    add_row(8'h10, make_keys(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    add_row(8'h01, make_keys(8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09));
    // same keys in another order
    add_row(8'h01, make_keys(8'h09, 8'h08, 8'h07, 8'h06, 8'h05, 8'h04), 0);
    add_row(8'h10, make_keys(8'h04, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    add_row(8'h00, make_keys(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00), 1, 8'h04, 1'b0);

    foreach (directed_rows[r]) begin
      row = directed_rows[r];
      send_report(row.mods, row.keys);
      queue_events(row.mods, row.keys, row.n_typed, row.ev);
    end
    wait_for_events();

    // random reports; a gap-free stretch and a full drain in the middle
    for (int n = 0; n < 200; n++) begin
      no_gaps = (n >= 80) && (n < 120);
      if (n == 140) wait_for_events();
      mods = 8'($urandom_range(0, 255));
      keys = random_keys();
      send_report(mods, keys);
      queue_events(mods, keys, -1, row.ev);
    end
    no_gaps = 1'b0;

    wait_for_events();
    repeat (16) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+sv
sv/hkrd_pkg.sv
sv/hkrd_front.sv
sv/hkrd_fifo.sv
sv/hkrd_back.sv
sv/hid_keyboard_report_diff.sv
sv/hkrd_checker.sv
dv/testbench.sv
